FILE: rtl/core/ecao_pkg.sv
// shared types, constants and control structs for the cellular automaton oscillator
package ecao_pkg;

  localparam int unsigned WIDTH_W    = 8;
  localparam int unsigned RULE_W     = 8;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned LFSR_W     = 32;
  localparam int unsigned SUM_W      = 15;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SEED_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef logic [WIDTH_W-1:0]         width_t;
  typedef logic [RULE_W-1:0]          rule_t;
  typedef logic [PERIOD_W-1:0]        period_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [LFSR_W-1:0]          lfsr_t;
  typedef logic [SUM_W-1:0]           sum_t;
  typedef logic [Q_W-1:0]             quo_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SEED_W-1:0]          seed_t;

  localparam lfsr_t   LFSR_SEED    = 32'hA5A5A5A5;
  localparam lfsr_t   LFSR_TAPS    = 32'h80200003;
  localparam cnt_t    ONE_TICK     = 25'd256;
  localparam period_t PERIOD_MIN   = 24'd256;
  localparam period_t PERIOD_RESET = 24'd256;
  localparam width_t  WIDTH_RESET  = 8'd255;
  localparam rule_t   RULE_RESET   = 8'd0;
  localparam width_t  DIV_LAST     = width_t'(Q_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RULE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_PERIOD = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DECIDE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic fill_step;
    logic decide;
    logic sum_step;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fill_lfsr;
    logic w_zero;
    logic idx_last;
    logic evolve_now;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/ecao_if.sv
// channel interfaces: tick input, sample output and register write port
interface ecao_in_if;
  logic                  valid;
  logic                  ready;
  logic                  reexcite;
  logic [ecao_pkg::SEED_W-1:0] seed_byte;

  modport source (output valid, reexcite, seed_byte, input ready);
  modport sink   (input valid, reexcite, seed_byte, output ready);
endinterface

interface ecao_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [ecao_pkg::SAMPLE_W-1:0] sample;
  logic                           evolved;

  modport source (output valid, sample, evolved, input ready);
  modport sink   (input valid, sample, evolved, output ready);
endinterface

interface ecao_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ecao_pkg::CFG_IDX_W-1:0]    index;
  logic [ecao_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ecao_ctrl.sv
// sequencing state machine for fill, step, weighted sum and divide
module ecao_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ecao_pkg::status_t status_i,
  output ecao_pkg::cmd_t    cmd_o
);

  ecao_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecao_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ecao_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.fill_lfsr ? ecao_pkg::ST_FILL : ecao_pkg::ST_DECIDE;
        end
      end
      ecao_pkg::ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.idx_last) begin
          state_d = ecao_pkg::ST_DECIDE;
        end
      end
      ecao_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (status_i.evolve_now) begin
          state_d = status_i.w_zero ? ecao_pkg::ST_DIV : ecao_pkg::ST_SUM;
        end else begin
          state_d = ecao_pkg::ST_DONE;
        end
      end
      ecao_pkg::ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (status_i.idx_last) begin
          state_d = ecao_pkg::ST_DIV;
        end
      end
      ecao_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ecao_pkg::ST_DONE;
        end
      end
      ecao_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ecao_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ecao_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/ecao_dp.sv
// datapath: cell row, lfsr, tick counter, serial weighted sum, restoring divider
module ecao_dp #(
  parameter int CELL_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ecao_in_if.sink           in_i,
  ecao_out_if.source        out_o,
  ecao_cfg_if.sink          cfg_i,
  input  ecao_pkg::cmd_t    cmd_i,
  output ecao_pkg::status_t status_o
);

  logic [CELL_COUNT-1:0] cells_q, cells_d;
  logic [CELL_COUNT-1:0] old_q;

  ecao_pkg::rule_t   rule_q;
  ecao_pkg::width_t  width_q;
  ecao_pkg::period_t period_q;

  ecao_pkg::lfsr_t   lfsr_q, lfsr_d;
  ecao_pkg::cnt_t    cnt_q;
  ecao_pkg::width_t  idx_q;
  ecao_pkg::sum_t    acc_q;
  ecao_pkg::sum_t    den_q;
  ecao_pkg::quo_t    quo_q;
  logic              neg_q;
  logic              evolved_q;
  ecao_pkg::sample_t held_q;

  logic              out_valid_q;
  ecao_pkg::sample_t out_sample_q;
  logic              out_evolved_q;

  ecao_pkg::width_t  w_eff;
  ecao_pkg::period_t period_eff;
  logic              evolve_now;
  logic              seed_load;
  logic              evolve_load;
  ecao_pkg::cnt_t    cnt_base;
  logic [2*ecao_pkg::WIDTH_W-1:0] w_prod;
  logic [ecao_pkg::SUM_W:0]       rem_dbl;
  logic              rem_ge;
  ecao_pkg::sample_t result;

  // effective width and period
  assign w_eff = (32'(width_q) < CELL_COUNT) ? width_q : ecao_pkg::width_t'(CELL_COUNT);
  assign period_eff = (period_q < ecao_pkg::PERIOD_MIN) ? ecao_pkg::PERIOD_MIN : period_q;
  assign evolve_now = cnt_q >= {1'b0, period_eff};

  assign seed_load   = cmd_i.accept && in_i.reexcite && (in_i.seed_byte != '0);
  assign evolve_load = cmd_i.decide && evolve_now;

  assign lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? ecao_pkg::LFSR_TAPS : '0);

  // per-cell next value
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    localparam int L = (i == 0) ? CELL_COUNT - 1 : i - 1;
    localparam int R = (i == CELL_COUNT - 1) ? 0 : i + 1;
    localparam int B = i % 8;
    logic act;
    assign act = 32'(w_eff) > 32'(i);
    assign cells_d[i] = (seed_load && act) ? in_i.seed_byte[B]
                      : (cmd_i.fill_step && (32'(idx_q) == 32'(i))) ? lfsr_q[0]
                      : (evolve_load && act) ? rule_q[{cells_q[L], cells_q[i], cells_q[R]}]
                      : cells_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= '0;
    end else begin
      cells_q <= cells_d;
    end
  end

  // register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q   <= ecao_pkg::RULE_RESET;
      width_q  <= ecao_pkg::WIDTH_RESET;
      period_q <= ecao_pkg::PERIOD_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ecao_pkg::REG_RULE:   rule_q   <= cfg_i.data[ecao_pkg::RULE_W-1:0];
        ecao_pkg::REG_WIDTH:  width_q  <= cfg_i.data[ecao_pkg::WIDTH_W-1:0];
        ecao_pkg::REG_PERIOD: period_q <= cfg_i.data[ecao_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // lfsr, tick counter, index counter
  assign cnt_base = evolve_now ? (cnt_q - {1'b0, period_eff}) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= ecao_pkg::LFSR_SEED;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.fill_step) begin
        lfsr_q <= lfsr_d;
      end
      if (cmd_i.decide) begin
        cnt_q <= cnt_base + ecao_pkg::ONE_TICK;
      end
      if (cmd_i.accept || cmd_i.decide) begin
        idx_q <= '0;
      end else if (cmd_i.sum_step && status_o.idx_last) begin
        idx_q <= '0;
      end else if (cmd_i.fill_step || cmd_i.sum_step || cmd_i.div_step) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // weighted sum and restoring divide
  assign w_prod  = (w_eff == '0) ? '0 : w_eff * (w_eff - 1'b1);
  assign rem_dbl = {acc_q, 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (evolve_load) begin
      old_q     <= cells_q;
      neg_q     <= cells_q[0];
      acc_q     <= '0;
      den_q     <= ecao_pkg::sum_t'(w_prod >> 1) + 1'b1;
    end else if (cmd_i.sum_step) begin
      old_q <= old_q >> 1;
      acc_q <= acc_q + (old_q[0] ? ecao_pkg::sum_t'(idx_q) : '0);
    end else if (cmd_i.div_step) begin
      acc_q <= rem_ge ? ecao_pkg::sum_t'(rem_dbl - {1'b0, den_q})
                      : rem_dbl[ecao_pkg::SUM_W-1:0];
      quo_q <= {quo_q[ecao_pkg::Q_W-2:0], rem_ge};
    end
    if (cmd_i.decide) begin
      evolved_q <= evolve_now;
    end
  end

  // output register
  assign result = evolved_q ? (neg_q ? (16'sd0 - ecao_pkg::sample_t'({1'b0, quo_q}))
                                     : ecao_pkg::sample_t'({1'b0, quo_q}))
                            : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
      held_q      <= result;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_sample_q  <= result;
      out_evolved_q <= evolved_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.sample  = out_sample_q;
  assign out_o.evolved = out_evolved_q;

  // status
  assign status_o.fill_lfsr  = in_i.reexcite && (in_i.seed_byte == '0) && (w_eff != '0);
  assign status_o.w_zero     = (w_eff == '0);
  assign status_o.idx_last   = (idx_q == w_eff - 1'b1);
  assign status_o.evolve_now = evolve_now;
  assign status_o.div_last   = (idx_q == ecao_pkg::DIV_LAST);
  assign status_o.out_free   = !out_valid_q || out_o.ready;

endmodule

FILE: rtl/core/elementary_ca_audio_oscillator.sv
// top level of the elementary cellular automaton audio oscillator
// each tick runs a decision and waits for the output; a re-excite with a
// zero seed adds an lfsr refill of w cells, and an evolution adds the serial
// weighted sum (one cell per cycle) and the 15-step restoring divider
// (w = effective active width, up to 255); one tick in flight at a time
// reset: cells zero, tick counter zero, held sample zero, lfsr at its seed
module elementary_ca_audio_oscillator #(
  parameter int CELL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecao_in_if.sink     in_i,
  ecao_out_if.source  out_o,
  ecao_cfg_if.sink    cfg_i
);

  ecao_pkg::cmd_t    cmd;
  ecao_pkg::status_t status;

  ecao_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ecao_dp #(
    .CELL_COUNT (CELL_COUNT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again while a tick is in progress");

  a_decide_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !status.fill_lfsr) |=> cmd.decide)
    else $error("tick decision missing after a beat without lfsr fill");

  a_sum_nonzero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sum_step |-> !status.w_zero)
    else $error("weighted sum running with zero width");

endmodule
